@@ design/rmth_pkg.sv @@
// ---------------------------------------------------------------------------
// rmth_pkg
// Shared constants, types and helpers for the two-heap running median.
// ---------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

   // storage per heap
   localparam int HEAP_DEPTH = 512;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

   // item widths
   localparam int SAMPLE_W   = 32;
   localparam int MEDIAN_W   = 33;
   localparam int COUNT_W    = 11;
   localparam int RSP_DATA_W = ((MEDIAN_W + COUNT_W + 7) / 8) * 8;

   // heap engine operations
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_SIFT = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] value;
      logic [CNT_W-1:0]           count;
   } heap_cmd_type;

   // heap ordering: true when a belongs above b
   function automatic logic above(input logic signed [SAMPLE_W-1:0] a,
                                  input logic signed [SAMPLE_W-1:0] b,
                                  input logic is_max);
      above = is_max ? (a > b) : (a < b);
   endfunction

endpackage

`default_nettype wire

@@ design/running_median_two_heaps.sv @@
// ---------------------------------------------------------------------------
// running_median_two_heaps
// Running median of signed 32-bit samples kept in a max-heap and a min-heap.
// ---------------------------------------------------------------------------
// Usage:
//   req_* takes one sample per item (tdata = sample).
//   rsp_* returns one item per sample: tdata = median_twice, sample_count;
//   tuser = dropped. median_twice is twice the median of all held samples.
//   Each sample costs at most one root replace with sift-down on one heap
//   and one push with sift-up on the other; both heap engines run at once.
//   Sift-down and sift-up are each limited by the single read port of the
//   heap RAM, which holds 512 entries per heap.
//   A new sample is taken only when the engines are idle, from the edge that
//   loads the result on; the finished result waits in the output register,
//   so the next sample may be accepted while the receiver stalls. A result
//   waits for the register to free up.
//   With both heaps full the sample is dropped and tuser is set.
//   Reset empties both heaps (counts to zero); no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps
   import rmth_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SAMPLE_W-1:0]   req_tdata,   // [31:0] sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [32:0] median_twice, [43:33] sample_count
   output logic                       rsp_tuser    // [0] dropped
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_BUSY   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(HEAP_DEPTH);

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     lo_cnt_ff, lo_cnt_in, up_cnt_ff, up_cnt_in;
   logic                 pend_lo_ff, pend_lo_in, pend_up_ff, pend_up_in;
   logic                 drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic                 lo_go, up_go, lo_done, up_done;
   heap_cmd_type         lo_cmd, up_cmd;
   logic signed [SAMPLE_W-1:0] lo_top, up_top, s;
   logic                 accept, to_lower, lo_more;
   logic signed [MEDIAN_W-1:0] median;
   logic [CNT_W:0]       total;

   rmth_heap u_lower (
      .clock     (clock),
      .reset     (reset),
      .is_max    (1'b1),
      .cmd_valid (lo_go),
      .cmd       (lo_cmd),
      .done      (lo_done),
      .top       (lo_top)
   );

   rmth_heap u_upper (
      .clock     (clock),
      .reset     (reset),
      .is_max    (1'b0),
      .cmd_valid (up_go),
      .cmd       (up_cmd),
      .done      (up_done),
      .top       (up_top)
   );

   assign s          = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign to_lower   = (lo_cnt_ff == '0) || (s <= lo_top);
   assign lo_more    = (lo_cnt_ff != up_cnt_ff);

   // median from the root copies
   always_comb begin
      total = (CNT_W+1)'(lo_cnt_ff) + (CNT_W+1)'(up_cnt_ff);
      if (lo_more) begin
         median = MEDIAN_W'(lo_top) <<< 1;
      end else if (lo_cnt_ff != '0) begin
         median = MEDIAN_W'(lo_top) + MEDIAN_W'(up_top);
      end else begin
         median = '0;
      end
   end

   // item dispatch and result hand-off
   always_comb begin
      state_in     = state_ff;
      lo_cnt_in    = lo_cnt_ff;
      up_cnt_in    = up_cnt_ff;
      pend_lo_in   = pend_lo_ff && !lo_done;
      pend_up_in   = pend_up_ff && !up_done;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      lo_go        = 1'b0;
      up_go        = 1'b0;
      lo_cmd       = '{op: OP_PUSH, value: s, count: lo_cnt_ff};
      up_cmd       = '{op: OP_PUSH, value: s, count: up_cnt_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               drop_in  = 1'b0;
               state_in = S_BUSY;
               if (lo_cnt_ff == FULL && up_cnt_ff == FULL) begin
                  drop_in = 1'b1;
               end else if (to_lower && lo_more) begin
                  // lower top or the sample crosses to the upper heap
                  up_go     = 1'b1;
                  up_cnt_in = up_cnt_ff + CNT_W'(1);
                  if (s < lo_top) begin
                     lo_go        = 1'b1;
                     lo_cmd.op    = OP_SIFT;
                     up_cmd.value = lo_top;
                  end
               end else if (to_lower) begin
                  lo_go     = 1'b1;
                  lo_cnt_in = lo_cnt_ff + CNT_W'(1);
               end else if (!lo_more) begin
                  // upper top or the sample crosses to the lower heap
                  lo_go     = 1'b1;
                  lo_cnt_in = lo_cnt_ff + CNT_W'(1);
                  if (up_top < s) begin
                     up_go        = 1'b1;
                     up_cmd.op    = OP_SIFT;
                     lo_cmd.value = up_top;
                  end
               end else begin
                  up_go     = 1'b1;
                  up_cnt_in = up_cnt_ff + CNT_W'(1);
               end
               pend_lo_in = lo_go;
               pend_up_in = up_go;
            end
         end
         S_BUSY: begin
            if (!pend_lo_ff && !pend_up_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({COUNT_W'(total), median});
               rsp_user_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lo_cnt_ff    <= '0;
         up_cnt_ff    <= '0;
         pend_lo_ff   <= 1'b0;
         pend_up_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lo_cnt_ff    <= lo_cnt_in;
         up_cnt_ff    <= up_cnt_in;
         pend_lo_ff   <= pend_lo_in;
         pend_up_ff   <= pend_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // heaps stay balanced: lower holds as many or one more
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (lo_cnt_ff == up_cnt_ff) || (lo_cnt_ff == up_cnt_ff + CNT_W'(1)))
      else $error("heap counts out of balance");

   // counts never pass the storage size
   a_bound: assert property (@(posedge clock) disable iff (reset)
      (lo_cnt_ff <= FULL) && (up_cnt_ff <= FULL))
      else $error("heap count beyond depth");

   // no engine work outstanding while a new item may enter
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!pend_lo_ff && !pend_up_ff))
      else $error("engine busy while accepting");

   // a result is loaded only when the register is free or being emptied
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_FINISH))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ design/rmth_ram.sv @@
// ---------------------------------------------------------------------------
// rmth_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ design/rmth_heap.sv @@
// ---------------------------------------------------------------------------
// rmth_heap
// One binary heap in RAM with a sift engine: push (sift up from the end)
// or replace the root and sift down. Keeps a copy of the root in a register.
// ---------------------------------------------------------------------------
`default_nettype none

module rmth_heap
   import rmth_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       is_max,
   input  wire logic                       cmd_valid,
   input  wire heap_cmd_type               cmd,
   output logic                            done,
   output logic signed [SAMPLE_W-1:0]      top
);

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_UP    = 3'd1;
   localparam logic [2:0] E_UPCMP = 3'd2;
   localparam logic [2:0] E_DN    = 3'd3;
   localparam logic [2:0] E_DN2   = 3'd4;
   localparam logic [2:0] E_DNCMP = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic signed [SAMPLE_W-1:0] c1_ff, c1_in;
   logic                       has2_ff, has2_in;
   logic signed [SAMPLE_W-1:0] top_ff;

   logic                       we;
   logic [IDX_W-1:0]           waddr, raddr;
   logic signed [SAMPLE_W-1:0] wdata, rdata;

   logic [IDX_W-1:0]           parent, j1, j2;
   logic [CNT_W:0]             j1_ext, j2_ext, n_ext;
   logic signed [SAMPLE_W-1:0] best;
   logic [IDX_W-1:0]           best_idx;

   rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // tree addressing
   always_comb begin
      parent = (i_ff - IDX_W'(1)) >> 1;
      j1_ext = ((CNT_W+1)'(i_ff) << 1) + (CNT_W+1)'(1);
      j2_ext = j1_ext + (CNT_W+1)'(1);
      n_ext  = (CNT_W+1)'(n_ff);
      j1     = j1_ext[IDX_W-1:0];
      j2     = j2_ext[IDX_W-1:0];
      if (has2_ff && above(rdata, c1_ff, is_max)) begin
         best     = rdata;
         best_idx = j2;
      end else begin
         best     = c1_ff;
         best_idx = j1;
      end
   end

   // sift sequencer, hole method: the moving value stays in v_ff
   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      c1_in    = c1_ff;
      has2_in  = has2_ff;
      we       = 1'b0;
      waddr    = i_ff;
      wdata    = v_ff;
      raddr    = parent;
      done     = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd_valid) begin
               v_in = cmd.value;
               n_in = cmd.count;
               if (cmd.op == OP_PUSH) begin
                  i_in     = cmd.count[IDX_W-1:0];
                  state_in = E_UP;
               end else begin
                  i_in     = '0;
                  state_in = E_DN;
               end
            end
         end
         E_UP: begin
            if (i_ff == '0) begin
               we       = 1'b1;
               done     = 1'b1;
               state_in = E_IDLE;
            end else begin
               raddr    = parent;
               state_in = E_UPCMP;
            end
         end
         E_UPCMP: begin
            we = 1'b1;
            if (above(v_ff, rdata, is_max)) begin
               wdata    = rdata;
               i_in     = parent;
               state_in = E_UP;
            end else begin
               done     = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_DN: begin
            raddr = j1;
            if (j1_ext >= n_ext) begin
               we       = 1'b1;
               done     = 1'b1;
               state_in = E_IDLE;
            end else begin
               state_in = E_DN2;
            end
         end
         E_DN2: begin
            raddr    = j2;
            c1_in    = rdata;
            has2_in  = (j2_ext < n_ext);
            state_in = E_DNCMP;
         end
         E_DNCMP: begin
            we = 1'b1;
            if (above(best, v_ff, is_max)) begin
               wdata    = best;
               i_in     = best_idx;
               state_in = E_DN;
            end else begin
               done     = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      v_ff    <= v_in;
      i_ff    <= i_in;
      n_ff    <= n_in;
      c1_ff   <= c1_in;
      has2_ff <= has2_in;
      // root copy follows every write to the root
      if (we && waddr == '0) begin
         top_ff <= wdata;
      end
   end

   assign top = top_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-heap running median: a scoreboard keeps its
// own pair of heaps, predicts median, count and drop flag for every accepted
// sample and compares each returned item in order.
// ---------------------------------------------------------------------------
`default_nettype none

// median predictor and store of expected items
class median_board_type;
   localparam int DEPTH = rmth_pkg::HEAP_DEPTH;

   typedef struct {
      logic signed [32:0] median_twice;
      logic [10:0]        sample_count;
      logic               dropped;
   } median_item_type;

   int lo_heap[DEPTH];
   int hi_heap[DEPTH];
   int lo_n;
   int hi_n;
   median_item_type pending[$];
   int errors;

   function new();
      lo_n = 0;
      hi_n = 0;
      errors = 0;
   endfunction

   // true when a belongs above b (max-heap if is_max)
   function bit ranks(int a, int b, bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   function void push_lo(int v);
      int i, p, t;
      i = lo_n;
      lo_heap[i] = v;
      lo_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks(lo_heap[i], lo_heap[p], 1)) break;
         t = lo_heap[p]; lo_heap[p] = lo_heap[i]; lo_heap[i] = t;
         i = p;
      end
   endfunction

   function void push_hi(int v);
      int i, p, t;
      i = hi_n;
      hi_heap[i] = v;
      hi_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks(hi_heap[i], hi_heap[p], 0)) break;
         t = hi_heap[p]; hi_heap[p] = hi_heap[i]; hi_heap[i] = t;
         i = p;
      end
   endfunction

   function void sink_lo(int n);
      int i, j, t;
      i = 0;
      while (2 * i + 1 < n) begin
         j = 2 * i + 1;
         if (j + 1 < n && ranks(lo_heap[j + 1], lo_heap[j], 1)) j++;
         if (!ranks(lo_heap[j], lo_heap[i], 1)) break;
         t = lo_heap[i]; lo_heap[i] = lo_heap[j]; lo_heap[j] = t;
         i = j;
      end
   endfunction

   function void sink_hi(int n);
      int i, j, t;
      i = 0;
      while (2 * i + 1 < n) begin
         j = 2 * i + 1;
         if (j + 1 < n && ranks(hi_heap[j + 1], hi_heap[j], 0)) j++;
         if (!ranks(hi_heap[j], hi_heap[i], 0)) break;
         t = hi_heap[i]; hi_heap[i] = hi_heap[j]; hi_heap[j] = t;
         i = j;
      end
   endfunction

   // note one accepted sample and queue its expected item
   function void note_sample(logic [31:0] raw);
      int s, v;
      bit to_lo;
      median_item_type m;
      longint med;
      s = raw;
      m.dropped = 0;
      if (lo_n >= DEPTH && hi_n >= DEPTH) begin
         m.dropped = 1;
      end else begin
         to_lo = (lo_n == 0) || (s <= lo_heap[0]);
         if (to_lo && lo_n >= DEPTH) begin
            // full lower heap: swap with the top when smaller
            if (s < lo_heap[0]) begin
               v = lo_heap[0];
               lo_heap[0] = s;
               sink_lo(lo_n);
               push_hi(v);
            end else begin
               push_hi(s);
            end
         end else if (to_lo) begin
            push_lo(s);
         end else begin
            push_hi(s);
         end
         // rebalance
         if (lo_n > hi_n + 1) begin
            v = lo_heap[0];
            lo_n--;
            lo_heap[0] = lo_heap[lo_n];
            sink_lo(lo_n);
            push_hi(v);
         end else if (hi_n > lo_n) begin
            v = hi_heap[0];
            hi_n--;
            hi_heap[0] = hi_heap[hi_n];
            sink_hi(hi_n);
            push_lo(v);
         end
      end
      med = 0;
      if (lo_n > hi_n) med = 2 * longint'(lo_heap[0]);
      else if (lo_n > 0) med = longint'(lo_heap[0]) + longint'(hi_heap[0]);
      m.median_twice = med[32:0];
      m.sample_count = 11'(lo_n + hi_n);
      pending.push_back(m);
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // compare one returned item with the oldest expectation
   task check_item(logic [32:0] med, logic [10:0] cnt, logic drp);
      median_item_type m;
      if (pending.size() == 0) begin
         report("unexpected item", med, 0);
         return;
      end
      m = pending.pop_front();
      if (med !== m.median_twice) report("median_twice", med, m.median_twice);
      if (cnt !== m.sample_count) report("sample_count", cnt, m.sample_count);
      if (drp !== m.dropped) report("dropped", drp, m.dropped);
   endtask
endclass

module tb_top;
   import rmth_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   median_board_type board = new();
   bit calm = 0;       // stretch with no idling
   int hold_off = 0;   // long receiver stall, in cycles

   running_median_two_heaps dut (.*);

   always #1 clock = ~clock;

   // one sample item, driven at the falling edge; valid stays up between
   // back-to-back items and drops only while idling
   task automatic send_sample(logic [31:0] s);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(s);
      @(negedge clock);
   endtask

   task automatic drain_wait();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return 32'($signed($urandom_range(40)) - 20);
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_item(rsp_tdata[32:0], rsp_tdata[43:33], rsp_tuser);
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes and ties
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h7fff_ffff);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      send_sample(32'hffff_ffff);
      send_sample(32'h0000_0001);
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h5555_5555);
      send_sample(32'haaaa_aaaa);
      // sender pauses until all results are in
      drain_wait();
      // long receiver stall while samples keep coming
      hold_off = 300;
      repeat (20) send_sample(rand_sample());
      // random fill, past the full store to reach the swap and drop cases
      for (int k = 0; k < 1700; k++) begin
         calm = (k >= 400 && k < 600);
         send_sample(rand_sample());
      end
      calm = 0;
      drain_wait();
      repeat (100) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire

@@ filelist.f @@
design/rmth_pkg.sv
design/rmth_ram.sv
design/rmth_heap.sv
design/running_median_two_heaps.sv
verif/tb_top.sv
